// ----- sv/pel_pkg.sv -----
// Shared constants, types and codes of the polyline envelope evaluator.
`timescale 1ns / 1ps
package pel_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int XY_W       = 2 * COORD_W;
  localparam int SEG_W      = COORD_W + 1;
  localparam int TOT_W      = SEG_W + IDX_W;
  localparam int AMT_W      = 17;
  localparam int TGT_W      = AMT_W + TOT_W;
  localparam int FRAC_W     = 16;
  localparam int DEN_W      = SEG_W + FRAC_W;
  localparam int RAD_W      = 2 * COORD_W + 2;
  localparam int NUM_W      = COORD_W + DEN_W + 1;
  localparam int QUO_W      = SEG_W;
  localparam int STEP_W     = 5;

  localparam int IDX_PORT_W = 10;
  localparam int CNT_PORT_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [AMT_W-1:0]   AMT_ONE        = AMT_W'(65536);
  localparam logic [COORD_W-1:0] WIDTH_RESET    = COORD_W'(8192);
  localparam logic [COORD_W-1:0] HEIGHT_RESET   = COORD_W'(4096);
  localparam logic [CNT_W-1:0]   CNT_DEFAULT    = CNT_W'(2);
  localparam logic [CNT_W-1:0]   CNT_FULL       = CNT_W'(MAX_POINTS);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVAL   = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_END_POINT = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;
endpackage

// ----- sv/pel_if.sv -----
// Valid/ready channel interfaces for operations and results.
`timescale 1ns / 1ps
interface pel_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [pel_pkg::COORD_W-1:0]      point_x;
  logic [pel_pkg::COORD_W-1:0]      point_y;
  logic [pel_pkg::IDX_PORT_W-1:0]   point_index;
  logic [pel_pkg::AMT_W-1:0]        amount;
  modport source (output valid, opcode, point_x, point_y, point_index, amount, input ready);
  modport sink   (input valid, opcode, point_x, point_y, point_index, amount, output ready);
endinterface

interface pel_out_if;
  logic                             valid;
  logic                             ready;
  logic [pel_pkg::COORD_W-1:0]      result_y;
  logic [1:0]                       status;
  logic [pel_pkg::CNT_PORT_W-1:0]   count_now;
  modport source (output valid, result_y, status, count_now, input ready);
  modport sink   (input valid, result_y, status, count_now, output ready);
endinterface

// ----- sv/pel_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module pel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/pel_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module pel_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pel_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [pel_pkg::SEG_W-1:0]  root
);
  localparam int W = pel_pkg::RAD_W;

  logic [W-1:0]                v_r, r_r, bit_r;
  logic [pel_pkg::STEP_W-1:0]  k_r;
  logic                        run_r, done_r;
  logic [W-1:0]                trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r   <= radicand;
        r_r   <= '0;
        bit_r <= W'(1) << (W - 2);
        k_r   <= pel_pkg::STEP_W'(W / 2);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        k_r   <= k_r - 1'b1;
        if (k_r == pel_pkg::STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[pel_pkg::SEG_W-1:0];
endmodule

// ----- sv/pel_div.sv -----
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps
module pel_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pel_pkg::NUM_W-1:0]  num,
  input  logic [pel_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [pel_pkg::QUO_W-1:0]  quo
);
  localparam int NW = pel_pkg::NUM_W;
  localparam int QW = pel_pkg::QUO_W;

  logic [NW-1:0]               n_r, d_r;
  logic [QW-1:0]               q_r;
  logic [pel_pkg::STEP_W-1:0]  k_r;
  logic                        run_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r   <= num;
        d_r   <= NW'(den) << (QW - 1);
        q_r   <= '0;
        k_r   <= pel_pkg::STEP_W'(QW);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (n_r >= d_r) begin
          n_r <= n_r - d_r;
          q_r <= {q_r[QW-2:0], 1'b1};
        end else begin
          q_r <= {q_r[QW-2:0], 1'b0};
        end
        d_r <= d_r >> 1;
        k_r <= k_r - 1'b1;
        if (k_r == pel_pkg::STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ----- sv/polyline_envelope_arclength_eval.sv -----
// Top level: point table sequencer around the point and segment length memories.
// Insert shifts points up from the table end to its position, remove shifts later points down,
// reset rewrites the two end points and a rejected operation goes straight to its result.
// Evaluate walks the segments, then divides to interpolate or ends without interpolating;
// stale lengths are first rebuilt segment by segment on the square root unit.
// One operation at a time, each with one result transaction; after rst_n the two end points
// are written to the table before the first transaction is taken.
`timescale 1ns / 1ps
module polyline_envelope_arclength_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  pel_in_if.sink                              in_ch,
  pel_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [pel_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pel_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam int CW = pel_pkg::COORD_W;
  localparam int NW = pel_pkg::CNT_W;
  localparam int IW = pel_pkg::IDX_W;
  localparam int PW = pel_pkg::IDX_PORT_W;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_INS_RD, S_INS_CHK, S_REM_RD, S_REM_WR,
    S_LEN_RD0, S_LEN_LAT, S_LEN_RD, S_LEN_MUL, S_LEN_SQ, S_LEN_WAIT,
    S_EV_MUL, S_EV_RD0, S_EV_Y0, S_EV_RD, S_EV_CHK, S_EV_M1, S_EV_M2, S_EV_DIV,
    S_FIN
  } state_t;

  state_t                           state_r;
  logic                             por_r;
  logic [CW-1:0]                    width_r, height_r;
  logic [NW-1:0]                    cnt_r, ptr_r;
  logic [pel_pkg::TOT_W-1:0]        total_r, acc_r;
  logic                             valid_r;
  logic [CW-1:0]                    px_r, py_r, prev_x_r, prev_y_r, y1_r, d_r;
  logic [pel_pkg::AMT_W-1:0]        amt_r;
  logic [pel_pkg::TGT_W-1:0]        target_r;
  logic [pel_pkg::DEN_W-1:0]        den_r, rem_r;
  logic                             down_r;
  logic [2*CW-1:0]                  sqx_r, sqy_r;
  logic [CW+pel_pkg::SEG_W-1:0]     prod_r;
  logic [CW-1:0]                    res_y_r;
  pel_pkg::status_t                 status_r;
  logic                             out_valid_r;
  logic [CW-1:0]                    out_y_r;
  logic [1:0]                       out_status_r;
  logic [pel_pkg::CNT_PORT_W-1:0]   out_count_r;

  logic                             xy_we, seg_we;
  logic [IW-1:0]                    xy_waddr, xy_raddr, seg_waddr, seg_raddr;
  logic [pel_pkg::XY_W-1:0]         xy_wdata, xy_rdata;
  logic [pel_pkg::SEG_W-1:0]        seg_rdata, root;
  logic [CW-1:0]                    rd_x, rd_y, dx, dy;
  logic                             sq_done, div_done;
  logic [pel_pkg::QUO_W-1:0]        quo;
  logic [pel_pkg::NUM_W-1:0]        num;
  logic [2*CW-1:0]                  lo_prod;
  logic [pel_pkg::TOT_W-1:0]        seg_end;
  logic [NW+PW-1:0]                 idx_ext, cnt_ext;
  logic                             in_fire;

  assign rd_x     = xy_rdata[2*CW-1:CW];
  assign rd_y     = xy_rdata[CW-1:0];
  assign dx       = (rd_x >= prev_x_r) ? rd_x - prev_x_r : prev_x_r - rd_x;
  assign dy       = (rd_y >= prev_y_r) ? rd_y - prev_y_r : prev_y_r - rd_y;
  assign seg_end  = acc_r + pel_pkg::TOT_W'(seg_rdata);
  assign lo_prod  = d_r * rem_r[pel_pkg::FRAC_W-1:0];
  assign num      = (pel_pkg::NUM_W'(prod_r) << pel_pkg::FRAC_W)
                  + pel_pkg::NUM_W'(lo_prod)
                  + pel_pkg::NUM_W'(den_r >> 1);
  assign idx_ext  = (NW+PW)'(in_ch.point_index);
  assign cnt_ext  = (NW+PW)'(cnt_r);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    xy_we     = 1'b0;
    xy_waddr  = ptr_r[IW-1:0];
    xy_wdata  = {px_r, py_r};
    xy_raddr  = ptr_r[IW-1:0];
    seg_we    = 1'b0;
    seg_waddr = IW'(ptr_r - 1'b1);
    seg_raddr = ptr_r[IW-1:0];
    unique case (state_r)
      S_INIT0: begin
        xy_we    = 1'b1;
        xy_waddr = '0;
        xy_wdata = '0;
      end
      S_INIT1: begin
        xy_we    = 1'b1;
        xy_waddr = IW'(1);
        xy_wdata = por_r ? {pel_pkg::WIDTH_RESET, pel_pkg::HEIGHT_RESET}
                         : {width_r, height_r};
      end
      S_INS_RD: begin
        xy_raddr = IW'(ptr_r - 1'b1);
        xy_we    = (ptr_r == '0);
      end
      S_INS_CHK: begin
        xy_we    = 1'b1;
        xy_wdata = (rd_x > px_r) ? xy_rdata : {px_r, py_r};
      end
      S_REM_RD: xy_raddr = IW'(ptr_r + 1'b1);
      S_REM_WR: begin
        xy_we    = 1'b1;
        xy_wdata = xy_rdata;
      end
      S_LEN_RD0, S_EV_RD0: xy_raddr = '0;
      S_LEN_WAIT: seg_we = sq_done;
      S_EV_RD: xy_raddr = IW'(ptr_r + 1'b1);
      default: ;
    endcase
  end

  pel_ram #(.WIDTH(pel_pkg::XY_W), .DEPTH(pel_pkg::MAX_POINTS)) u_xy (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(xy_wdata),
    .raddr(xy_raddr), .rdata(xy_rdata)
  );

  pel_ram #(.WIDTH(pel_pkg::SEG_W), .DEPTH(pel_pkg::MAX_POINTS)) u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(root),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  pel_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_LEN_SQ),
    .radicand(pel_pkg::RAD_W'(sqx_r) + pel_pkg::RAD_W'(sqy_r)),
    .done(sq_done), .root(root)
  );

  pel_div u_div (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_EV_M2),
    .num(num), .den(den_r), .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      por_r       <= 1'b1;
      width_r     <= pel_pkg::WIDTH_RESET;
      height_r    <= pel_pkg::HEIGHT_RESET;
      cnt_r       <= pel_pkg::CNT_DEFAULT;
      total_r     <= '0;
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pel_pkg::CFG_WIDTH) begin
          width_r <= cfg_data;
        end else begin
          height_r <= cfg_data;
        end
      end
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT0: state_r <= S_INIT1;
        S_INIT1: begin
          cnt_r    <= pel_pkg::CNT_DEFAULT;
          total_r  <= '0;
          valid_r  <= 1'b0;
          por_r    <= 1'b0;
          res_y_r  <= '0;
          status_r <= pel_pkg::ST_OK;
          state_r  <= por_r ? S_IDLE : S_FIN;
        end
        S_IDLE: begin
          if (in_fire) begin
            px_r     <= in_ch.point_x;
            py_r     <= in_ch.point_y;
            amt_r    <= (in_ch.amount > pel_pkg::AMT_ONE) ? pel_pkg::AMT_ONE : in_ch.amount;
            res_y_r  <= '0;
            status_r <= pel_pkg::ST_OK;
            unique case (pel_pkg::op_t'(in_ch.opcode))
              pel_pkg::OP_INSERT: begin
                if (cnt_r >= pel_pkg::CNT_FULL) begin
                  status_r <= pel_pkg::ST_FULL;
                  state_r  <= S_FIN;
                end else begin
                  ptr_r   <= cnt_r;
                  state_r <= S_INS_RD;
                end
              end
              pel_pkg::OP_REMOVE: begin
                if (idx_ext >= cnt_ext) begin
                  status_r <= pel_pkg::ST_BAD_INDEX;
                  state_r  <= S_FIN;
                end else if (idx_ext == '0 || idx_ext + 1'b1 == cnt_ext) begin
                  status_r <= pel_pkg::ST_END_POINT;
                  state_r  <= S_FIN;
                end else begin
                  ptr_r   <= idx_ext[NW-1:0];
                  state_r <= S_REM_RD;
                end
              end
              pel_pkg::OP_EVAL: begin
                if (valid_r) begin
                  state_r <= S_EV_MUL;
                end else begin
                  total_r <= '0;
                  state_r <= S_LEN_RD0;
                end
              end
              default: state_r <= S_INIT0;
            endcase
          end
        end
        S_INS_RD: begin
          if (ptr_r == '0) begin
            cnt_r   <= cnt_r + 1'b1;
            valid_r <= 1'b0;
            state_r <= S_FIN;
          end else begin
            state_r <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          if (rd_x > px_r) begin
            ptr_r   <= ptr_r - 1'b1;
            state_r <= S_INS_RD;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            valid_r <= 1'b0;
            state_r <= S_FIN;
          end
        end
        S_REM_RD: state_r <= S_REM_WR;
        S_REM_WR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r + NW'(2) == cnt_r) begin
            cnt_r   <= cnt_r - 1'b1;
            valid_r <= 1'b0;
            state_r <= S_FIN;
          end else begin
            state_r <= S_REM_RD;
          end
        end
        S_LEN_RD0: begin
          ptr_r   <= NW'(1);
          state_r <= S_LEN_LAT;
        end
        S_LEN_LAT: begin
          prev_x_r <= rd_x;
          prev_y_r <= rd_y;
          state_r  <= S_LEN_RD;
        end
        S_LEN_RD: state_r <= S_LEN_MUL;
        S_LEN_MUL: begin
          sqx_r    <= dx * dx;
          sqy_r    <= dy * dy;
          prev_x_r <= rd_x;
          prev_y_r <= rd_y;
          state_r  <= S_LEN_SQ;
        end
        S_LEN_SQ: state_r <= S_LEN_WAIT;
        S_LEN_WAIT: begin
          if (sq_done) begin
            total_r <= total_r + pel_pkg::TOT_W'(root);
            ptr_r   <= ptr_r + 1'b1;
            if (ptr_r + 1'b1 == cnt_r) begin
              valid_r <= 1'b1;
              state_r <= S_EV_MUL;
            end else begin
              state_r <= S_LEN_RD;
            end
          end
        end
        S_EV_MUL: begin
          target_r <= amt_r * total_r;
          acc_r    <= '0;
          ptr_r    <= '0;
          state_r  <= S_EV_RD0;
        end
        S_EV_RD0: state_r <= S_EV_Y0;
        S_EV_Y0: begin
          y1_r    <= rd_y;
          state_r <= S_EV_RD;
        end
        S_EV_RD: state_r <= S_EV_CHK;
        S_EV_CHK: begin
          if ((pel_pkg::TGT_W'(seg_end) << pel_pkg::FRAC_W) >= target_r) begin
            if (seg_rdata == '0) begin
              res_y_r <= y1_r;
              state_r <= S_FIN;
            end else begin
              den_r   <= pel_pkg::DEN_W'(seg_rdata) << pel_pkg::FRAC_W;
              rem_r   <= pel_pkg::DEN_W'(target_r
                         - (pel_pkg::TGT_W'(acc_r) << pel_pkg::FRAC_W));
              d_r     <= (rd_y >= y1_r) ? rd_y - y1_r : y1_r - rd_y;
              down_r  <= (rd_y < y1_r);
              state_r <= S_EV_M1;
            end
          end else begin
            acc_r <= seg_end;
            y1_r  <= rd_y;
            ptr_r <= ptr_r + 1'b1;
            if (ptr_r + NW'(2) == cnt_r) begin
              res_y_r <= rd_y;
              state_r <= S_FIN;
            end else begin
              state_r <= S_EV_RD;
            end
          end
        end
        S_EV_M1: begin
          prod_r  <= d_r * rem_r[pel_pkg::DEN_W-1:pel_pkg::FRAC_W];
          state_r <= S_EV_M2;
        end
        S_EV_M2: state_r <= S_EV_DIV;
        S_EV_DIV: begin
          if (div_done) begin
            res_y_r <= down_r ? y1_r - quo[CW-1:0] : y1_r + quo[CW-1:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_y_r      <= res_y_r;
            out_status_r <= status_r;
            out_count_r  <= pel_pkg::CNT_PORT_W'(cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result_y  = out_y_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count_now = out_count_r;
endmodule

// ----- sv/pel_checker.sv -----
// Port-level checker for the polyline envelope evaluator, bound to the top level.
`timescale 1ns / 1ps
module pel_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [pel_pkg::COORD_W-1:0]         result_y,
  input logic [1:0]                          status,
  input logic [pel_pkg::CNT_PORT_W-1:0]      count_now
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_y) && $stable(status)
      && $stable(count_now))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_now >= pel_pkg::CNT_PORT_W'(2)
      && count_now <= pel_pkg::CNT_PORT_W'(pel_pkg::MAX_POINTS))
    else $error("point count out of range");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == pel_pkg::ST_FULL
      |-> count_now == pel_pkg::CNT_PORT_W'(pel_pkg::MAX_POINTS))
    else $error("table full reported with room left");

  a_status_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != pel_pkg::ST_OK |-> result_y == '0)
    else $error("non-zero y on a rejected operation");
endmodule

bind polyline_envelope_arclength_eval pel_checker u_pel_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result_y(out_ch.result_y), .status(out_ch.status), .count_now(out_ch.count_now)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the polyline envelope evaluator with its own table model.
`timescale 1ns / 1ps
module tb_top;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int TABLE_SOFT_CAP = 16;
  localparam int BIG_TABLE = 64;

  typedef struct {
    logic [pel_pkg::COORD_W-1:0]    result_y;
    pel_pkg::status_t               status;
    logic [pel_pkg::CNT_PORT_W-1:0] count_now;
  } envelope_result_t;

  class envelope_scoreboard;
    logic [pel_pkg::COORD_W-1:0] width_reg;
    logic [pel_pkg::COORD_W-1:0] height_reg;
    logic [pel_pkg::COORD_W-1:0] xs [pel_pkg::MAX_POINTS];
    logic [pel_pkg::COORD_W-1:0] ys [pel_pkg::MAX_POINTS];
    logic [pel_pkg::SEG_W-1:0]   seg_len [pel_pkg::MAX_POINTS];
    int unsigned        count;
    longint unsigned    total_len;
    bit                 lengths_ok;
    envelope_result_t   awaited [$];
    int                 errors;

    function new();
      width_reg = pel_pkg::WIDTH_RESET;
      height_reg = pel_pkg::HEIGHT_RESET;
      errors = 0;
      restore_table();
    endfunction

    function void restore_table();
      xs[0] = '0;
      ys[0] = '0;
      xs[1] = width_reg;
      ys[1] = height_reg;
      count = 2;
      total_len = 0;
      lengths_ok = 0;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [pel_pkg::COORD_W-1:0] arc_eval(logic [pel_pkg::AMT_W-1:0] amt);
      longint unsigned a, target, acc, seg, den, rem, d, q, dx, dy;
      a = (amt > pel_pkg::AMT_ONE) ? pel_pkg::AMT_ONE : amt;
      if (!lengths_ok) begin
        total_len = 0;
        for (int i = 0; i + 1 < count; i++) begin
          dx = (xs[i+1] >= xs[i]) ? xs[i+1] - xs[i] : xs[i] - xs[i+1];
          dy = (ys[i+1] >= ys[i]) ? ys[i+1] - ys[i] : ys[i] - ys[i+1];
          seg_len[i] = pel_pkg::SEG_W'(int_root(dx * dx + dy * dy));
          total_len += seg_len[i];
        end
        lengths_ok = 1;
      end
      target = a * total_len;
      acc = 0;
      for (int i = 0; i + 1 < count; i++) begin
        seg = seg_len[i];
        if (((acc + seg) << 16) >= target) begin
          if (seg == 0) return ys[i];
          den = seg << 16;
          rem = target - (acc << 16);
          if (ys[i+1] >= ys[i]) begin
            d = ys[i+1] - ys[i];
            q = (d * rem + den / 2) / den;
            return pel_pkg::COORD_W'(ys[i] + q);
          end
          d = ys[i] - ys[i+1];
          q = (d * rem + den / 2) / den;
          return pel_pkg::COORD_W'(ys[i] - q);
        end
        acc += seg;
      end
      return ys[count-1];
    endfunction

    function void note_op(pel_pkg::op_t op, logic [pel_pkg::COORD_W-1:0] x,
                          logic [pel_pkg::COORD_W-1:0] y,
                          logic [pel_pkg::IDX_PORT_W-1:0] idx,
                          logic [pel_pkg::AMT_W-1:0] amt);
      envelope_result_t e;
      int unsigned pos;
      e.result_y = '0;
      e.status = pel_pkg::ST_OK;
      case (op)
        pel_pkg::OP_INSERT: begin
          if (count >= pel_pkg::MAX_POINTS) begin
            e.status = pel_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < count && xs[pos] <= x) pos++;
            for (int i = count; i > pos; i--) begin
              xs[i] = xs[i-1];
              ys[i] = ys[i-1];
            end
            xs[pos] = x;
            ys[pos] = y;
            count++;
            lengths_ok = 0;
          end
        end
        pel_pkg::OP_REMOVE: begin
          if (idx >= count) begin
            e.status = pel_pkg::ST_BAD_INDEX;
          end else if (idx == 0 || idx + 1 == count) begin
            e.status = pel_pkg::ST_END_POINT;
          end else begin
            for (int i = idx; i + 1 < count; i++) begin
              xs[i] = xs[i+1];
              ys[i] = ys[i+1];
            end
            count--;
            lengths_ok = 0;
          end
        end
        pel_pkg::OP_EVAL: e.result_y = arc_eval(amt);
        default: restore_table();
      endcase
      e.count_now = pel_pkg::CNT_PORT_W'(count);
      awaited.push_back(e);
    endfunction

    function void check_result(logic [pel_pkg::COORD_W-1:0] ry, logic [1:0] st,
                               logic [pel_pkg::CNT_PORT_W-1:0] cn);
      envelope_result_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result transaction: result_y %0d status %0d count_now %0d",
               ry, st, cn);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (ry !== e.result_y) begin
        $error("result_y: expected %0d, actual %0d", e.result_y, ry);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (cn !== e.count_now) begin
        $error("count_now: expected %0d, actual %0d", e.count_now, cn);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pel_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pel_pkg::CFG_DATA_W-1:0] cfg_data;

  pel_in_if in_ch ();
  pel_out_if out_ch ();

  polyline_envelope_arclength_eval dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  envelope_scoreboard board;
  bit calm;
  bit hold_req;
  int unsigned cycle_count;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    int hold_left;
    int stall_left;
    bit hold_done;
    hold_left = 0;
    stall_left = 0;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.result_y, out_ch.status, out_ch.count_now);
        stall_left = pick_gap();
      end
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n;
      end
    end
  end

  task automatic send_op(pel_pkg::op_t op, logic [pel_pkg::COORD_W-1:0] x,
                         logic [pel_pkg::COORD_W-1:0] y,
                         logic [pel_pkg::IDX_PORT_W-1:0] idx,
                         logic [pel_pkg::AMT_W-1:0] amt);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_index <= idx;
    in_ch.amount <= amt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_op(op, x, y, idx, amt);
  endtask

  task automatic drain_and_idle();
    if (in_ch.valid) begin
      in_ch.valid <= 1'b0;
    end
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_canvas(logic [pel_pkg::COORD_W-1:0] w,
                              logic [pel_pkg::COORD_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= pel_pkg::CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= pel_pkg::CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.width_reg = w;
    board.height_reg = h;
    send_op(pel_pkg::OP_RESET, '0, '0, '0, '0);
  endtask

  task automatic random_op();
    int r;
    logic [pel_pkg::COORD_W-1:0] x;
    logic [pel_pkg::IDX_PORT_W-1:0] idx;
    logic [pel_pkg::AMT_W-1:0] amt;
    r = $urandom_range(0, 99);
    x = pel_pkg::COORD_W'($urandom());
    if ($urandom_range(0, 3) == 0) x = board.xs[$urandom_range(0, board.count - 1)];
    idx = pel_pkg::IDX_PORT_W'($urandom_range(0, board.count));
    if ($urandom_range(0, 9) == 0) idx = pel_pkg::IDX_PORT_W'($urandom());
    amt = pel_pkg::AMT_W'($urandom_range(0, 65536));
    if ($urandom_range(0, 9) == 0) amt = pel_pkg::AMT_W'($urandom());
    if (board.count >= TABLE_SOFT_CAP && r < 40) r = (r < 30) ? 40 : 95;
    if (r < 40) send_op(pel_pkg::OP_INSERT, x, 16'($urandom()), idx, amt);
    else if (r < 60) send_op(pel_pkg::OP_REMOVE, x, 16'($urandom()), idx, amt);
    else if (r < 93) send_op(pel_pkg::OP_EVAL, x, 16'($urandom()), idx, amt);
    else send_op(pel_pkg::OP_RESET, x, 16'($urandom()), idx, amt);
  endtask

  initial begin
    board = new();
    calm = 0;
    hold_req = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= pel_pkg::CFG_WIDTH;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= pel_pkg::OP_INSERT;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_index <= '0;
    in_ch.amount <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(pel_pkg::OP_EVAL, '0, '0, '0, '0);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, pel_pkg::AMT_ONE);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'h1FFFF);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd32768);
    send_op(pel_pkg::OP_INSERT, 16'd0, 16'd0, '0, '0);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, '0);
    send_op(pel_pkg::OP_INSERT, 16'd8192, 16'hFFFF, '0, '0);
    send_op(pel_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, '0, '0);
    send_op(pel_pkg::OP_INSERT, 16'd4000, 16'd100, '0, '0);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd1);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd65535);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd40000);
    send_op(pel_pkg::OP_REMOVE, '0, '0, 10'd0, '0);
    send_op(pel_pkg::OP_REMOVE, '0, '0, 10'(board.count - 1), '0);
    send_op(pel_pkg::OP_REMOVE, '0, '0, 10'h3FF, '0);
    send_op(pel_pkg::OP_REMOVE, '0, '0, 10'(board.count), '0);
    send_op(pel_pkg::OP_REMOVE, '0, '0, 10'd1, '0);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd20000);
    send_op(pel_pkg::OP_RESET, '0, '0, '0, '0);
    drain_and_idle();

    write_canvas('0, '0);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd30000);
    send_op(pel_pkg::OP_INSERT, 16'd0, 16'd500, '0, '0);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, pel_pkg::AMT_ONE);
    drain_and_idle();
    write_canvas(16'hFFFF, 16'hFFFF);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd12345);

    for (int n = 0; n < 480; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 200) hold_req = 1;
      if (n % 135 == 134) begin
        drain_and_idle();
        write_canvas(16'($urandom()), 16'($urandom()));
      end
      random_op();
    end
    drain_and_idle();

    write_canvas(16'($urandom()), 16'($urandom()));
    calm = 1;
    while (board.count < BIG_TABLE) begin
      send_op(pel_pkg::OP_INSERT, 16'($urandom()), 16'($urandom()), '0, '0);
    end
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'($urandom_range(0, 65536)));
    send_op(pel_pkg::OP_REMOVE, '0, '0, 10'd32, '0);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, pel_pkg::AMT_ONE);
    send_op(pel_pkg::OP_RESET, '0, '0, '0, '0);
    calm = 0;
    drain_and_idle();
    write_canvas(pel_pkg::WIDTH_RESET, pel_pkg::HEIGHT_RESET);
    send_op(pel_pkg::OP_EVAL, '0, '0, '0, 17'd50000);
    drain_and_idle();

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
